// ===== src/fdp_pkg.sv =====
// Shared types, constants and job record for the FAT directory entry parser.
package fdp_pkg;

	localparam int ENTRY_BYTES    = 32;
	localparam int POS_W          = $clog2(ENTRY_BYTES);
	localparam int UNITS_PER_PART = 13;
	localparam int SHORT_LEN      = 11;
	localparam int BASE_LEN       = 8;
	localparam int EXT_LEN        = SHORT_LEN - BASE_LEN;
	localparam int CHAR_IDX_W     = $clog2(UNITS_PER_PART + 1);
	localparam int CHAR_POS_W     = 10;
	localparam int JOB_DEPTH      = 2;

	localparam logic [POS_W-1:0] LAST_POS  = POS_W'(ENTRY_BYTES - 1);
	localparam logic [POS_W-1:0] SUM_LIMIT = POS_W'(SHORT_LEN);
	localparam logic [POS_W-1:0] ATTR_POS  = POS_W'(11);
	localparam logic [POS_W-1:0] CSUM_POS  = POS_W'(13);

	localparam logic [7:0] MARK_ERASED     = 8'hE5;
	localparam logic [7:0] MARK_KANJI      = 8'h05;
	localparam logic [7:0] SEQ_LAST_FLAG   = 8'h40;
	localparam logic [7:0] ROT_TOP         = 8'h80;
	localparam logic [7:0] ATTR_LONG       = 8'h0F;
	localparam logic [7:0] ATTR_DEV_UNUSED = 8'hC0;
	localparam logic [7:0] CHAR_NUL        = 8'h00;
	localparam logic [7:0] CHAR_SPACE      = 8'h20;
	localparam logic [7:0] CHAR_DOT        = 8'h2E;

	// Byte offsets of the low byte of each UTF-16 unit in a long-name part
	localparam logic [POS_W-1:0] UNIT_OFF [UNITS_PER_PART] = '{
		5'd1, 5'd3, 5'd5, 5'd7, 5'd9, 5'd14, 5'd16, 5'd18, 5'd20, 5'd22, 5'd24, 5'd28, 5'd30
	};

	typedef enum logic [2:0] {
		CLS_END,
		CLS_ERASED,
		CLS_LFN_PART,
		CLS_DEVICE,
		CLS_SHORT,
		CLS_LONG,
		CLS_BAD_SEQ
	} entry_class_t;

	typedef enum logic {
		KIND_CHAR,
		KIND_SUMMARY
	} record_kind_t;

	// One classified entry, handed from the front end to the emitter
	typedef struct packed {
		entry_class_t                             cls;
		logic                                     name_ready;
		logic [CHAR_IDX_W-1:0]                    nchars;
		logic [CHAR_POS_W-1:0]                    base_pos;
		logic [UNITS_PER_PART-1:0][7:0]           chars;
		logic [7:0]                               attr;
		logic [15:0]                              clus;
		logic [31:0]                              size;
	} job_t;

endpackage

// ===== src/fdp_if.sv =====
// Valid/ready channel interfaces: raw byte stream in, parsed records out.
interface fdp_byte_if import fdp_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source(output valid, output data_byte, input ready);
	modport sink(input valid, input data_byte, output ready);
endinterface

interface fdp_rec_if import fdp_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic                  record_kind;
	logic [CHAR_POS_W-1:0] char_pos;
	logic [7:0]            char_value;
	logic [2:0]            entry_class;
	logic                  name_ready;
	logic [7:0]            attr_bits;
	logic [15:0]           start_cluster;
	logic [31:0]           byte_size;
	logic                  last;

	modport source(output valid, output record_kind, output char_pos, output char_value,
		output entry_class, output name_ready, output attr_bits, output start_cluster,
		output byte_size, output last, input ready);
	modport sink(input valid, input record_kind, input char_pos, input char_value,
		input entry_class, input name_ready, input attr_bits, input start_cluster,
		input byte_size, input last, output ready);
endinterface

// ===== src/fat_dir_entry_parser.sv =====
// FAT directory entry parser top level: front end, entry queue, record emitter.
// The first record of an entry is registered at the emitter output after the entry is written into the queue.
// Throughput: one byte per cycle; an entry yields up to 14 records from the emitter, one per
//   cycle unless result.ready is low; byte 31 waits only while the two-entry queue is full.
// Reset (arst_n low, asynchronous): byte position, checksum, long-name state, queue
//   and output valid clear; the 31-byte entry buffer is not reset and is rewritten per entry.
module fat_dir_entry_parser import fdp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	fdp_byte_if.sink   stream,
	fdp_rec_if.source  result
);

	logic push;
	logic pop;
	logic full;
	logic empty;
	job_t new_job;
	job_t head_job;

	// Buffer bytes, track checksum and long-name run, classify on the last byte
	fdp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream),
		.full   (full),
		.push   (push),
		.job    (new_job)
	);

	// Decouple classification from emission so the byte side keeps streaming
	fdp_job_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (new_job),
		.pop      (pop),
		.head_job (head_job),
		.empty    (empty),
		.full     (full)
	);

	// Emit name characters, then the summary beat marked last
	fdp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_job (head_job),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

endmodule

// ===== src/fdp_front.sv =====
// Front end: buffers entry bytes, keeps the checksum and long-name state, classifies entries.
module fdp_front import fdp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	fdp_byte_if.sink  stream,
	input  logic      full,
	output logic      push,
	output job_t      job
);

	logic [POS_W-1:0] pos_q;
	logic [7:0]       sum_q;
	logic             lfn_active_q;
	logic [7:0]       saved_sum_q;
	logic [7:0]       buf_q [ENTRY_BYTES-1];

	logic             accept;
	logic             at_end;
	logic             lfn_active_d;
	logic             save_sum;
	logic [7:0]       e0;
	logic [7:0]       attr;
	logic [7:0]       seq;
	logic [5:0]       seq_m1;
	logic [7:0]       base_b [BASE_LEN];
	logic [7:0]       ext_b [BASE_LEN];
	logic [3:0]       bl;
	logic [3:0]       xl;
	logic [3:0]       j;
	logic [7:0]       short_c [UNITS_PER_PART];

	function automatic logic [3:0] trim_len(input logic [7:0] b [BASE_LEN]);
		logic [3:0] len;
		logic       stop;
		len  = '0;
		stop = 1'b0;
		for (int k = 0; k < BASE_LEN; k++) begin
			if (!stop && b[k] != CHAR_NUL) begin
				len = 4'(k + 1);
			end else begin
				stop = 1'b1;
			end
		end
		for (int k = BASE_LEN - 1; k >= 0; k--) begin
			if (len == 4'(k + 1) && b[k] == CHAR_SPACE) begin
				len = 4'(k);
			end
		end
		return len;
	endfunction

	// Only the closing byte of an entry can stall, and only on a full queue
	assign at_end       = (pos_q == LAST_POS);
	assign stream.ready = !at_end || !full;
	assign accept       = stream.valid && stream.ready;
	assign push         = accept && at_end;

	assign e0     = buf_q[0];
	assign attr   = buf_q[ATTR_POS];
	assign seq    = e0 & ~SEQ_LAST_FLAG;
	assign seq_m1 = seq[5:0] - 6'd1;

	always_comb begin
		for (int k = 0; k < BASE_LEN; k++) begin
			base_b[k] = buf_q[k];
			ext_b[k]  = (k < EXT_LEN) ? buf_q[BASE_LEN + k] : CHAR_NUL;
		end
		bl = trim_len(base_b);
		xl = trim_len(ext_b);
		// Assemble the 8.3 name: base, dot, extension
		for (int i = 0; i < UNITS_PER_PART; i++) begin
			j = 4'(i) - bl - 4'd1;
			if (4'(i) < bl) begin
				short_c[i] = (i == 0 && buf_q[0] == MARK_KANJI) ? MARK_ERASED : buf_q[i];
			end else if (4'(i) == bl) begin
				short_c[i] = CHAR_DOT;
			end else if (j < 4'(EXT_LEN)) begin
				short_c[i] = buf_q[BASE_LEN + int'(j[1:0])];
			end else begin
				short_c[i] = CHAR_NUL;
			end
		end
	end

	always_comb begin
		lfn_active_d    = lfn_active_q;
		save_sum        = 1'b0;
		job.cls         = CLS_END;
		job.name_ready  = 1'b0;
		job.nchars      = '0;
		job.base_pos    = '0;
		job.attr        = attr;
		job.clus        = {buf_q[27], buf_q[26]};
		job.size        = {stream.data_byte, buf_q[30], buf_q[29], buf_q[28]};
		for (int k = 0; k < UNITS_PER_PART; k++) begin
			job.chars[k] = buf_q[UNIT_OFF[k]];
		end
		if (e0 == CHAR_NUL) begin
			job.cls = CLS_END;
		end else if (e0 == MARK_ERASED) begin
			job.cls      = CLS_ERASED;
			lfn_active_d = 1'b0;
		end else if (attr == ATTR_LONG) begin
			if (seq == 8'd0 || seq[7]) begin
				job.cls      = CLS_BAD_SEQ;
				lfn_active_d = 1'b0;
			end else begin
				job.cls      = CLS_LFN_PART;
				job.nchars   = CHAR_IDX_W'(UNITS_PER_PART);
				job.base_pos = CHAR_POS_W'(seq_m1) * CHAR_POS_W'(UNITS_PER_PART);
				lfn_active_d = 1'b1;
				save_sum     = 1'b1;
			end
		end else if ((attr & ATTR_DEV_UNUSED) != 8'd0) begin
			job.cls      = CLS_DEVICE;
			lfn_active_d = 1'b0;
		end else if (lfn_active_q && saved_sum_q == sum_q) begin
			job.cls        = CLS_LONG;
			job.name_ready = 1'b1;
			lfn_active_d   = 1'b0;
		end else begin
			job.cls        = CLS_SHORT;
			job.name_ready = 1'b1;
			job.nchars     = CHAR_IDX_W'(bl + ((xl != 4'd0) ? (xl + 4'd1) : 4'd0));
			for (int k = 0; k < UNITS_PER_PART; k++) begin
				job.chars[k] = short_c[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			sum_q        <= '0;
			lfn_active_q <= 1'b0;
			saved_sum_q  <= '0;
		end else if (accept) begin
			pos_q <= pos_q + POS_W'(1);
			if (pos_q == '0) begin
				sum_q <= stream.data_byte;
			end else if (pos_q < SUM_LIMIT) begin
				sum_q <= (sum_q[0] ? ROT_TOP : 8'd0) + (sum_q >> 1) + stream.data_byte;
			end
			if (at_end) begin
				lfn_active_q <= lfn_active_d;
				if (save_sum) begin
					saved_sum_q <= buf_q[CSUM_POS];
				end
			end
		end
	end

	// Entry bytes, no reset
	always_ff @(posedge clk) begin
		if (accept && !at_end) begin
			buf_q[pos_q] <= stream.data_byte;
		end
	end

endmodule

// ===== src/fdp_job_fifo.sv =====
// Small register queue of classified entries between front end and emitter.
module fdp_job_fifo import fdp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output job_t head_job,
	output logic empty,
	output logic full
);

	localparam int PTR_W = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
	localparam int CNT_W = $clog2(JOB_DEPTH + 1);

	job_t             mem_q [JOB_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign empty    = (cnt_q == '0);
	assign full     = (cnt_q == CNT_W'(JOB_DEPTH));
	assign head_job = mem_q[rd_q];

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(JOB_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= bump(wr_q);
			end
			if (pop) begin
				rd_q <= bump(rd_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

endmodule

// ===== src/fdp_back.sv =====
// Emitter: walks the head entry, one name character per beat, then the summary record.
module fdp_back import fdp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  job_t       head_job,
	input  logic       empty,
	output logic       pop,
	fdp_rec_if.source  result
);

	logic [CHAR_IDX_W-1:0] k_q;
	logic                  valid_q;
	logic                  load;
	logic                  is_sum;

	assign load   = !empty && (!valid_q || result.ready);
	assign is_sum = (k_q == head_job.nchars);
	assign pop    = load && is_sum;

	assign result.valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			k_q     <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				k_q     <= is_sum ? '0 : k_q + CHAR_IDX_W'(1);
			end else if (result.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Output payload, held while stalled
	always_ff @(posedge clk) begin
		if (load) begin
			result.entry_class <= head_job.cls;
			if (is_sum) begin
				result.record_kind   <= KIND_SUMMARY;
				result.char_pos      <= '0;
				result.char_value    <= '0;
				result.name_ready    <= head_job.name_ready;
				result.attr_bits     <= head_job.attr;
				result.start_cluster <= head_job.clus;
				result.byte_size     <= head_job.size;
				result.last          <= 1'b1;
			end else begin
				result.record_kind   <= KIND_CHAR;
				result.char_pos      <= head_job.base_pos + CHAR_POS_W'(k_q);
				result.char_value    <= head_job.chars[k_q];
				result.name_ready    <= 1'b0;
				result.attr_bits     <= '0;
				result.start_cluster <= '0;
				result.byte_size     <= '0;
				result.last          <= 1'b0;
			end
		end
	end

endmodule
